// ===== design/sukt_pkg.sv =====
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared types, codes and constants of the sorted unique key table.
// ----------------------------------------------------------------------------
`default_nettype none

package sukt_pkg;

   localparam int DEPTH_DEFAULT = 64;
   localparam int KEY_W         = 16;
   localparam int YEAR_W        = 12;
   localparam int ENTRY_W       = KEY_W + YEAR_W;
   localparam int COUNT_W       = 7;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_REPORT = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   typedef struct packed {
      logic [1:0]        operation;
      logic [KEY_W-1:0]  member_key;
      logic [YEAR_W-1:0] join_year;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic               entry_valid;
      logic [KEY_W-1:0]   entry_key;
      logic [YEAR_W-1:0]  entry_year;
      logic               last_of_run;
      logic [COUNT_W-1:0] record_count;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_INS_SHIFT,
      S_REM_SHIFT,
      S_REPLY,
      S_REPORT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       idx_clear;
      logic       idx_step;
      logic       ins_write;
      logic       rem_write;
      logic       count_up;
      logic       count_down;
      logic       rsp_load;
      logic [1:0] rsp_status;
      logic       rsp_entry;
      logic       rsp_last;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       in_range;
      logic       key_lt;
      logic       key_eq;
      logic       full;
      logic       empty;
      logic       last_entry;
      logic       rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/sukt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sukt_ctrl
// Sequencer: search, shift up on insert, shift down on remove, report walk.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic [1:0]         req_op,
   output logic                    req_ready,
   input  wire sukt_pkg::stat_type stat,
   output sukt_pkg::cmd_type       cmd
);

   sukt_pkg::state_type state_ff, state_in;
   logic [1:0]          status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sukt_pkg::S_IDLE;
         status_ff <= sukt_pkg::ST_OK;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         sukt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture   = 1'b1;
               cmd.idx_clear = 1'b1;
               if (req_op == sukt_pkg::OP_INSERT || req_op == sukt_pkg::OP_REMOVE) begin
                  state_in = sukt_pkg::S_SCAN;
               end else if (req_op == sukt_pkg::OP_REPORT) begin
                  state_in = sukt_pkg::S_REPORT;
               end
            end
         end
         sukt_pkg::S_SCAN: begin
            if (stat.in_range && stat.key_lt) begin
               cmd.idx_step = 1'b1;
            end else if (stat.op == sukt_pkg::OP_INSERT) begin
               if (stat.in_range && stat.key_eq) begin
                  status_in = sukt_pkg::ST_DUPLICATE;
                  state_in  = sukt_pkg::S_REPLY;
               end else if (stat.full) begin
                  status_in = sukt_pkg::ST_FULL;
                  state_in  = sukt_pkg::S_REPLY;
               end else begin
                  state_in = sukt_pkg::S_INS_SHIFT;
               end
            end else begin
               if (stat.in_range && stat.key_eq) begin
                  cmd.idx_step = 1'b1;
                  state_in     = sukt_pkg::S_REM_SHIFT;
               end else begin
                  status_in = sukt_pkg::ST_NOT_FOUND;
                  state_in  = sukt_pkg::S_REPLY;
               end
            end
         end
         sukt_pkg::S_INS_SHIFT: begin
            cmd.ins_write = 1'b1;
            if (stat.in_range) begin
               cmd.idx_step = 1'b1;
            end else begin
               cmd.count_up = 1'b1;
               status_in    = sukt_pkg::ST_OK;
               state_in     = sukt_pkg::S_REPLY;
            end
         end
         sukt_pkg::S_REM_SHIFT: begin
            if (stat.in_range) begin
               cmd.rem_write = 1'b1;
               cmd.idx_step  = 1'b1;
            end else begin
               cmd.count_down = 1'b1;
               status_in      = sukt_pkg::ST_OK;
               state_in       = sukt_pkg::S_REPLY;
            end
         end
         sukt_pkg::S_REPLY: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = status_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = sukt_pkg::S_IDLE;
            end
         end
         sukt_pkg::S_REPORT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = sukt_pkg::ST_OK;
               if (stat.empty) begin
                  cmd.rsp_last = 1'b1;
                  state_in     = sukt_pkg::S_IDLE;
               end else begin
                  cmd.rsp_entry = 1'b1;
                  cmd.rsp_last  = stat.last_entry;
                  cmd.idx_step  = 1'b1;
                  if (stat.last_entry) begin
                     state_in = sukt_pkg::S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = sukt_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/sukt_dp.sv =====
// ----------------------------------------------------------------------------
// sukt_dp
// Record memory, walk index, record count, carry register and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_dp #(
   parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sukt_pkg::req_type  req_data,
   input  wire sukt_pkg::cmd_type  cmd,
   output sukt_pkg::stat_type      stat,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output sukt_pkg::rsp_type       rsp_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [sukt_pkg::ENTRY_W-1:0] mem [DEPTH];

   logic [1:0]                    op_ff;
   logic [sukt_pkg::KEY_W-1:0]    key_ff;
   logic [sukt_pkg::ENTRY_W-1:0]  carry_ff, carry_in;
   logic [sukt_pkg::ENTRY_W-1:0]  rd_ff;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   sukt_pkg::rsp_type             rsp_data_ff;

   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic [sukt_pkg::ENTRY_W-1:0]  wr_data;
   logic [sukt_pkg::KEY_W-1:0]    rd_key;
   logic [sukt_pkg::YEAR_W-1:0]   rd_year;

   assign rd_key  = rd_ff[sukt_pkg::ENTRY_W-1:sukt_pkg::YEAR_W];
   assign rd_year = rd_ff[sukt_pkg::YEAR_W-1:0];

   always_comb begin
      priority if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + CW'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_comb begin
      priority if (cmd.count_up) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_down) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      priority if (cmd.capture) begin
         carry_in = {req_data.member_key, req_data.join_year};
      end else if (cmd.ins_write) begin
         carry_in = rd_ff;
      end else begin
         carry_in = carry_ff;
      end
   end

   always_comb begin
      wr_en   = cmd.ins_write || cmd.rem_write;
      wr_addr = cmd.ins_write ? idx_ff[AW-1:0] : AW'(idx_ff - CW'(1));
      wr_data = cmd.ins_write ? carry_ff : rd_ff;
   end

   // read port follows the next index, so rd_ff holds the entry at idx_ff
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         count_ff <= '0;
      end else begin
         idx_ff   <= idx_in;
         count_ff <= count_in;
      end
      carry_ff <= carry_in;
      if (cmd.capture) begin
         op_ff  <= req_data.operation;
         key_ff <= req_data.member_key;
      end
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.status       <= cmd.rsp_status;
         rsp_data_ff.entry_valid  <= cmd.rsp_entry;
         rsp_data_ff.entry_key    <= cmd.rsp_entry ? rd_key : '0;
         rsp_data_ff.entry_year   <= cmd.rsp_entry ? rd_year : '0;
         rsp_data_ff.last_of_run  <= cmd.rsp_last;
         rsp_data_ff.record_count <= sukt_pkg::COUNT_W'(count_ff);
      end
   end

   always_comb begin
      stat.op         = op_ff;
      stat.in_range   = idx_ff < count_ff;
      stat.key_lt     = rd_key < key_ff;
      stat.key_eq     = rd_key == key_ff;
      stat.full       = count_ff == CW'(DEPTH);
      stat.empty      = count_ff == '0;
      stat.last_entry = (idx_ff + CW'(1)) == count_ff;
      stat.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/sorted_unique_key_table.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_key_table
// Ordered table of unique 16-bit keys with a 12-bit year per record.
//
//   channel   dir   handshake              payload
//   req_      in    req_valid/req_ready    sukt_pkg::req_type
//   rsp_      out   rsp_valid/rsp_ready    sukt_pkg::rsp_type
//
// One request at a time; req_ready is high only while the sequencer is idle.
// Insert: capture, search for the slot, shift the records from it up, reply;
// remove: capture, search, shift down, reply; report: one beat per record.
// Walk speed is one entry per cycle, set by the single memory read port.
// Reset is synchronous and empties the table; no clearing pass.
// A stalled rsp_ holds the walk; the result register frees a slot per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_key_table #(
   parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sukt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sukt_pkg::rsp_type      rsp_data
);

   sukt_pkg::cmd_type  cmd;
   sukt_pkg::stat_type stat;

   sukt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.operation),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sukt_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/sukt_check.sv =====
// ----------------------------------------------------------------------------
// sukt_check
// Port-level checks for the sorted unique key table.
// ----------------------------------------------------------------------------
`default_nettype none

module sukt_check #(
   parameter int DEPTH = sukt_pkg::DEPTH_DEFAULT
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire sukt_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire sukt_pkg::rsp_type rsp_data
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat dropped or changed while stalled");

   a_busy_after_req : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.operation != sukt_pkg::OP_UNUSED |=> !req_ready)
      else $error("request taken while previous one in flight");

   a_plain_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.entry_valid |-> rsp_data.last_of_run)
      else $error("beat without record not marked last");

   a_entry_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.entry_valid |-> rsp_data.status == sukt_pkg::ST_OK)
      else $error("reported record with non-ok status");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (DEPTH > 127) || (int'(rsp_data.record_count) <= DEPTH))
      else $error("record count above depth");

endmodule

bind sorted_unique_key_table sukt_check #(
   .DEPTH (DEPTH)
) u_sukt_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
